/* hdl/bps_pkg.sv */
// Shared types and defaults for the buzzer pattern sequencer.
package bps_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_TIME_WIDTH  = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  note_slot;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [6:0]  pattern_length;
  } in_word_t;

  typedef struct packed {
    logic       buzzer_drive;
    logic       playing;
    logic [5:0] current_note;
    logic       pattern_done;
  } out_word_t;

endpackage

/* hdl/bps_note_mem.sv */
// Note table memory: one entry holds on and off time, registered read with write forwarding.
module bps_note_mem #(
  parameter int TABLE_DEPTH = bps_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = bps_pkg::DEF_TIME_WIDTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [2*TIME_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [2*TIME_WIDTH-1:0] rd_data_r
);

  logic [2*TIME_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // pass a same-cycle write straight through so the next read is current
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bps_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
module bps_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bps_pkg::out_word_t push_word,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bps_pkg::out_word_t out_word
);

  logic               main_v_r;
  logic               skid_v_r;
  bps_pkg::out_word_t main_d_r;
  bps_pkg::out_word_t skid_d_r;
  logic               pop;

  assign pop        = main_v_r && out_ready;
  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_word   = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        main_d_r <= skid_d_r;
        skid_v_r <= 1'b0;
      end else if (push) begin
        main_d_r <= push_word;
      end else begin
        main_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_d_r <= push_word;
        main_v_r <= 1'b1;
      end else begin
        skid_d_r <= push_word;
        skid_v_r <= 1'b1;
      end
    end
  end

endmodule

/* hdl/buzzer_pattern_sequencer_unit.sv */
// Top level of the buzzer pattern sequencer: play control, note table and result buffer.
//
// Plays beep patterns from a software-loaded note table. Each input word is a
// one-millisecond tick, a note write, a pattern start or a stop, and each one
// yields exactly one result word showing drive, playing, note index and the
// pattern_done pulse after that word is applied. The block takes one input word
// every clock cycle while in_ready is high: the note table sits in a synchronous
// memory whose read address is always the note position the control logic is
// about to hold, so the current note's times are registered and ready when the
// next word arrives; a note write to that same position is forwarded through
// the read register. Each result is registered in the two-word buffer, so
// one more input word is taken while the consumer stalls, and in_ready drops
// only when both entries are full. No clearing pass is run after reset; a note
// must be written before it is played.
module buzzer_pattern_sequencer_unit #(
  parameter int TABLE_DEPTH = bps_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = bps_pkg::DEF_TIME_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bps_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output bps_pkg::out_word_t out_word
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [TIME_WIDTH-1:0]   elapsed_r, elapsed_nxt;
  logic                    drive_r, drive_nxt;
  logic                    done;

  logic                    in_fire;
  logic                    wr_en;
  logic [2*TIME_WIDTH-1:0] wr_data;
  logic [2*TIME_WIDTH-1:0] rd_data_r;
  logic [TIME_WIDTH-1:0]   cur_on;
  logic [TIME_WIDTH-1:0]   cur_off;
  logic [TIME_WIDTH-1:0]   elapsed_inc;
  logic [LW-1:0]           pos_inc;
  logic [LW-1:0]           len_sat;
  bps_pkg::out_word_t      res_word;

  assign in_fire = in_valid && in_ready;
  assign cur_on  = rd_data_r[2*TIME_WIDTH-1:TIME_WIDTH];
  assign cur_off = rd_data_r[TIME_WIDTH-1:0];
  // store times truncated (or zero-extended) to the configured width
  assign wr_data = {TIME_WIDTH'(32'(in_word.on_time)), TIME_WIDTH'(32'(in_word.off_time))};

  // saturate the elapsed count at its maximum
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + TIME_WIDTH'(1);
  assign pos_inc     = LW'(pos_r) + LW'(1);
  assign len_sat     = (32'(in_word.pattern_length) > TABLE_DEPTH) ?
                       LW'(TABLE_DEPTH) : LW'(in_word.pattern_length);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    drive_nxt   = drive_r;
    done        = 1'b0;
    wr_en       = 1'b0;
    if (in_fire) begin
      case (in_word.op)
        bps_pkg::OP_WRITE: begin
          // drop writes beyond the table
          wr_en = (32'(in_word.note_slot) < TABLE_DEPTH);
        end
        bps_pkg::OP_START: begin
          if (in_word.pattern_length != '0) begin
            phase_nxt   = PH_ON;
            pos_nxt     = '0;
            len_nxt     = len_sat;
            elapsed_nxt = '0;
            drive_nxt   = 1'b1;
          end
        end
        bps_pkg::OP_STOP: begin
          phase_nxt   = PH_IDLE;
          pos_nxt     = '0;
          len_nxt     = '0;
          elapsed_nxt = '0;
          drive_nxt   = 1'b0;
        end
        bps_pkg::OP_TICK: begin
          if (phase_r == PH_ON) begin
            if (elapsed_inc >= cur_on) begin
              phase_nxt   = PH_OFF;
              elapsed_nxt = '0;
              drive_nxt   = 1'b0;
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end else if (phase_r == PH_OFF) begin
            if (elapsed_inc >= cur_off) begin
              elapsed_nxt = '0;
              if (pos_inc >= len_r) begin
                // last note finished: go idle and flag completion
                phase_nxt = PH_IDLE;
                pos_nxt   = '0;
                len_nxt   = '0;
                drive_nxt = 1'b0;
                done      = 1'b1;
              end else begin
                phase_nxt = PH_ON;
                pos_nxt   = AW'(pos_inc);
                drive_nxt = 1'b1;
              end
            end else begin
              elapsed_nxt = elapsed_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_word.buzzer_drive = drive_nxt;
    res_word.playing      = (phase_nxt != PH_IDLE);
    res_word.current_note = (phase_nxt != PH_IDLE) ? 6'(pos_nxt) : 6'd0;
    res_word.pattern_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      len_r     <= '0;
      elapsed_r <= '0;
      drive_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      elapsed_r <= elapsed_nxt;
      drive_r   <= drive_nxt;
    end
  end

  // read the note the control will hold next cycle
  bps_note_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_note_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(in_word.note_slot)),
    .wr_data   (wr_data),
    .rd_addr   (pos_nxt),
    .rd_data_r (rd_data_r)
  );

  bps_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_word  (res_word),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // idle holds a cleared position and the drive off
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (pos_r == '0 && !drive_r && len_r == '0))
    else $error("idle state not cleared");

  // while playing, the position stays inside the pattern
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (LW'(pos_r) < len_r))
    else $error("note position beyond pattern length");

  // an accepted stop always leaves the block idle
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.op == bps_pkg::OP_STOP) |=> (phase_r == PH_IDLE))
    else $error("stop did not return to idle");

  // drive on only in the on phase
  a_drive_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r |-> (phase_r == PH_ON))
    else $error("drive active outside on phase");

endmodule

/* bench/tb_buzzer_pattern_sequencer_unit.sv */
// Self-checking bench for the buzzer pattern sequencer: a directed table, then random words.
module tb_buzzer_pattern_sequencer_unit;
  import bps_pkg::*;

  localparam int DEPTH            = DEF_TABLE_DEPTH;
  localparam int RANDOM_WORDS     = 1900;   // words with an effect in the random part
  localparam int IDLE_PCT         = 21;     // chance per cycle that a side idles
  localparam int DRAIN_CYCLES     = 8;      // results pass through a registered 2-entry buffer
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PAUSE_EVERY      = 600;    // hold the sender until all results are back

  // Play phases of the sequencer as the bench tracks them.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ON,
    PH_OFF
  } play_phase_t;

  // One row of the directed table: the word to send and, where it is obvious,
  // the result typed in by hand; other rows take the predicted result.
  typedef struct packed {
    in_word_t  word;
    logic      fixed;
    out_word_t res;
  } dir_row_t;

  // Results read straight off the spec: {drive, playing, note, done}.
  localparam out_word_t OUT_QUIET    = 9'b0_0_000000_0;  // idle, buzzer off
  localparam out_word_t OUT_FIRST_ON = 9'b1_1_000000_0;  // pattern just started on note 0

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  buzzer_pattern_sequencer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Player model: note table, play phase and position, updated once per word.
  // ---------------------------------------------------------------------------
  logic [15:0] beep_on     [DEPTH];
  logic [15:0] beep_off    [DEPTH];
  bit          slot_loaded [DEPTH];
  int          loaded_run;          // slots 0 .. loaded_run-1 have all been written
  play_phase_t pl_phase;
  int          pl_note;
  int          pl_len;
  logic [15:0] pl_elapsed;
  logic        pl_drive;

  out_word_t   pending_results [$]; // expected result words, oldest first
  out_word_t   want_word;
  int          mismatches        = 0;
  int          results_seen      = 0;
  int          patterns_finished = 0;
  int          longest_start     = 0;
  int          useful_words      = 0;
  int          words_sent        = 0;
  bit          calm              = 1'b0; // both sides stop idling while set

  // Drop to idle: buzzer off, position, length and elapsed time cleared.
  function automatic void silence_player();
    pl_drive   = 1'b0;
    pl_phase   = PH_IDLE;
    pl_note    = 0;
    pl_len     = 0;
    pl_elapsed = '0;
  endfunction

  // Apply one accepted word to the model and return the result it causes.
  function automatic out_word_t advance_player(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.op)
      OP_WRITE: begin
        // New times apply at once, even to the note now playing.
        beep_on[w.note_slot]     = w.on_time;
        beep_off[w.note_slot]    = w.off_time;
        slot_loaded[w.note_slot] = 1'b1;
        while (loaded_run < DEPTH && slot_loaded[loaded_run]) loaded_run++;
      end
      OP_START: begin
        // Zero length is ignored; a start while playing restarts from note 0.
        if (w.pattern_length != 7'd0) begin
          pl_len     = (int'(w.pattern_length) > DEPTH) ? DEPTH : int'(w.pattern_length);
          pl_note    = 0;
          pl_phase   = PH_ON;
          pl_elapsed = '0;
          pl_drive   = 1'b1;
          if (pl_len > longest_start) longest_start = pl_len;
        end
      end
      OP_STOP: silence_player();
      default: begin
        // Tick: count, then compare; a zero time ends the phase on the first tick.
        if (pl_phase != PH_IDLE) begin
          if (pl_elapsed != 16'hFFFF) pl_elapsed = pl_elapsed + 16'd1;
          if (pl_phase == PH_ON) begin
            if (pl_elapsed >= beep_on[pl_note]) begin
              pl_drive   = 1'b0;
              pl_phase   = PH_OFF;
              pl_elapsed = '0;
            end
          end else if (pl_elapsed >= beep_off[pl_note]) begin
            pl_note++;
            if (pl_note >= pl_len) begin
              silence_player();
              r.pattern_done = 1'b1;
              patterns_finished++;
            end else begin
              pl_drive   = 1'b1;
              pl_phase   = PH_ON;
              pl_elapsed = '0;
            end
          end
        end
      end
    endcase
    r.buzzer_drive = pl_drive;
    r.playing      = (pl_phase != PH_IDLE);
    r.current_note = (pl_phase != PH_IDLE) ? pl_note[5:0] : 6'd0;
    return r;
  endfunction

  function automatic dir_row_t dir_row(op_t op, logic [5:0] slot, logic [15:0] on_t,
                                       logic [15:0] off_t, logic [6:0] len, logic fixed,
                                       out_word_t res);
    dir_row_t d;
    d.word.op             = op;
    d.word.note_slot      = slot;
    d.word.on_time        = on_t;
    d.word.off_time       = off_t;
    d.word.pattern_length = len;
    d.fixed               = fixed;
    d.res                 = res;
    return d;
  endfunction

  // Mostly short times so patterns finish; now and then a wide one.
  function automatic logic [15:0] pick_time();
    int          r;
    logic [31:0] bits;
    r = $urandom_range(99);
    if (r < 91) bits = $urandom_range(6);
    else if (r < 99) bits = $urandom_range(200, 7);
    else bits = $urandom;
    return bits[15:0];
  endfunction

  // Build a random word that never plays a note slot left unwritten.
  function automatic in_word_t pick_word();
    in_word_t    w;
    logic [31:0] bits;
    int          r;
    int          cap;
    int          len;
    // Fill unused fields with noise so every bit moves.
    bits             = $urandom;
    w.note_slot      = bits[5:0];
    w.pattern_length = bits[12:6];
    bits             = $urandom;
    w.on_time        = bits[15:0];
    w.off_time       = bits[31:16];
    r = $urandom_range(99);
    if (pl_phase == PH_IDLE)
      w.op = (r < 40) ? OP_START : (r < 75) ? OP_WRITE : (r < 90) ? OP_TICK : OP_STOP;
    else
      w.op = (r < 84) ? OP_TICK : (r < 95) ? OP_WRITE : (r < 98) ? OP_START : OP_STOP;
    if (w.op == OP_WRITE) begin
      // Favor the note now playing and the next unwritten slot.
      r = $urandom_range(99);
      if (pl_phase != PH_IDLE && r < 30) bits = pl_note;
      else if (loaded_run < DEPTH && r < 65) bits = loaded_run;
      else bits = $urandom_range(DEPTH - 1);
      w.note_slot = bits[5:0];
      w.on_time   = pick_time();
      w.off_time  = pick_time();
    end else if (w.op == OP_START) begin
      r   = $urandom_range(99);
      cap = (loaded_run < 8) ? loaded_run : 8;
      if (r < 5) len = 0;
      else if (loaded_run == DEPTH && r < 12) len = $urandom_range(127, DEPTH);
      else if (r < 20) len = $urandom_range(loaded_run, 1);
      else len = $urandom_range(cap, 1);
      bits = len;
      w.pattern_length = bits[6:0];
    end
    return w;
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic offer_word(input in_word_t w);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stall the result side at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every result word taken with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("result word %b arrived with nothing expected", out_word);
      end else begin
        want_word = pending_results.pop_front();
        if (out_word.buzzer_drive !== want_word.buzzer_drive ||
            out_word.playing      !== want_word.playing ||
            out_word.current_note !== want_word.current_note ||
            out_word.pattern_done !== want_word.pattern_done) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result %0d: expected drive=%b playing=%b note=%0d done=%b, got drive=%b playing=%b note=%0d done=%b",
                     results_seen, want_word.buzzer_drive, want_word.playing,
                     want_word.current_note, want_word.pattern_done, out_word.buzzer_drive,
                     out_word.playing, out_word.current_note, out_word.pattern_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, random words, drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t  directed [$];
    dir_row_t  row;
    in_word_t  word;
    out_word_t got;
    bit        counts;
    int        next_pause;

    for (int i = 0; i < DEPTH; i++) slot_loaded[i] = 1'b0;
    loaded_run = 0;
    silence_player();

    // Idle cases first, then a short pattern with zero times, a rewrite of the
    // note in play, restart, stop and a pattern that runs to its done pulse.
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_STOP,  6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_START, 6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_WRITE, 6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_WRITE, 6'd1,  16'd2,     16'd1,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_WRITE, 6'd2,  16'd1,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_WRITE, 6'd63, 16'hFFFF,  16'hFFFF,  7'd127, 1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_START, 6'd0,  16'd0,     16'd0,     7'd3,   1'b1, OUT_FIRST_ON));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_WRITE, 6'd1,  16'd2,     16'd3,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_START, 6'd0,  16'd0,     16'd0,     7'd2,   1'b1, OUT_FIRST_ON));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_STOP,  6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));
    directed.push_back(dir_row(OP_START, 6'd0,  16'd0,     16'd0,     7'd1,   1'b1, OUT_FIRST_ON));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b0, OUT_QUIET));
    directed.push_back(dir_row(OP_TICK,  6'd0,  16'd0,     16'd0,     7'd0,   1'b1, OUT_QUIET));

    // Hold reset low, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      offer_word(row.word);
      got = advance_player(row.word);
      pending_results.push_back(row.fixed ? row.res : got);
    end

    // Let the directed results drain before the random part starts.
    while (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end

    next_pause = PAUSE_EVERY;
    while (useful_words < RANDOM_WORDS) begin
      calm = (useful_words >= 800 && useful_words < 1100);
      if (useful_words >= next_pause) begin
        next_pause += PAUSE_EVERY;
        while (pending_results.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      word = pick_word();
      // Skip words the block just ignores when counting progress.
      counts = !((word.op == OP_START && word.pattern_length == 7'd0) ||
                 ((word.op == OP_TICK || word.op == OP_STOP) && pl_phase == PH_IDLE));
      offer_word(word);
      got = advance_player(word);
      pending_results.push_back(got);
      if (counts) useful_words++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Wait for the last results, then keep watching to catch strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d with effect in the random part); %0d patterns played to the end, longest start %0d notes",
             words_sent, useful_words, patterns_finished, longest_start);
    $display("checked %0d result words, %0d mismatches, %0d note slots loaded in order",
             results_seen, mismatches, loaded_run);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hdl/bps_pkg.sv
hdl/bps_note_mem.sv
hdl/bps_out_buf.sv
hdl/buzzer_pattern_sequencer_unit.sv
bench/tb_buzzer_pattern_sequencer_unit.sv
